// ===== rtl/kmm_pkg.sv =====
// Shared types, constants and helper functions for the keyed min/max/sum hash map.
// Used by the front end, the back end and the top module; depends on nothing else.
`default_nettype none

package kmm_pkg;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_EXACT = 2'd1,
    OP_PRICE = 2'd2,
    OP_CAP   = 2'd3
  } op_e;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    op_e                operation;
    logic [26:0]        date;
    logic [63:0]        currency_hi;
    logic [63:0]        currency_lo;
    logic [63:0]        exchange_hi;
    logic [63:0]        exchange_lo;
    logic signed [47:0] low_price;
    logic signed [47:0] high_price;
    logic signed [63:0] capital;
    logic               want_max;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic signed [47:0] found_low;
    logic signed [47:0] found_high;
    logic signed [63:0] found_capital;
    logic signed [47:0] chosen_price;
  } out_t;

  // Hashes are kept modulo 2^HASH_W; the bucket count is a power of two up to that.
  localparam int HASH_W = 20;
  typedef logic [HASH_W-1:0] hash_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    in_t   item;
    hash_t hash_raw;
    hash_t hash_price;
    hash_t hash_cap;
  } work_t;

  localparam logic [63:0] NAME_PRICE_HI = 64'h7072696365000000;
  localparam logic [63:0] NAME_CAP_HI   = 64'h6361700000000000;

  localparam logic [33:0] DATE_MUL = 34'd97;
  localparam logic [21:0] CUR_MUL  = 22'd881;
  localparam logic [21:0] EXC_MUL  = 22'd991;
  // Byte sums of "price" and "cap", already scaled by their multipliers.
  localparam logic [33:0] PRICE_TERM = 34'(531 * 991);
  localparam logic [33:0] CAP_TERM   = 34'(308 * 881);

  // Clear every byte after the first zero byte of a 16-byte name.
  function automatic logic [127:0] canon_name(input logic [127:0] name);
    logic [127:0] r;
    logic         ended;
    r     = name;
    ended = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (ended) begin
        r[127-8*i -: 8] = 8'h00;
      end else if (r[127-8*i -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

  // Sum of the bytes of a canonical name (bytes after the end are zero).
  function automatic logic [11:0] name_sum(input logic [127:0] name);
    logic [11:0] s;
    s = 12'd0;
    for (int i = 0; i < 16; i++) begin
      s = s + 12'(name[8*i +: 8]);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kmm_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package needed.
`default_nettype none

module kmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kmm_fifo.sv =====
// Small register queue used between the front end, the back end and the result port.
// Standalone; the payload type comes in as a type parameter.
`default_nettype none

module kmm_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                slot_q [DEPTH];
  logic [AW-1:0]   wp_q, rp_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rp_q];

  // Storage slots carry no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kmm_front.sv =====
// Front end: takes input transactions, canonicalizes the names and computes the
// three bucket hashes of an item. Depends on kmm_pkg.
`default_nettype none

module kmm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  kmm_pkg::in_t  item_i,
  output logic          full_o,
  input  logic          hold_i,
  output logic          wk_valid_o,
  input  logic          wk_ready_i,
  output kmm_pkg::work_t wk_o
);
  import kmm_pkg::*;

  logic        v_q;
  in_t         it_q;
  in_t         canon_w;
  logic        accept;
  logic [11:0] sum_cur, sum_exc;
  logic [33:0] date_term;
  logic [21:0] cur_term, exc_term;

  assign full_o = hold_i || (v_q && !wk_ready_i);
  assign accept = push_i && !full_o;

  // Names end at their first zero byte.
  always_comb begin
    canon_w = item_i;
    {canon_w.currency_hi, canon_w.currency_lo} =
      canon_name({item_i.currency_hi, item_i.currency_lo});
    {canon_w.exchange_hi, canon_w.exchange_lo} =
      canon_name({item_i.exchange_hi, item_i.exchange_lo});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (accept) begin
      v_q <= 1'b1;
    end else if (wk_ready_i) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_q <= canon_w;
    end
  end

  // Hash terms; the running modulo of the byte walk equals one final mask.
  assign sum_cur   = name_sum({it_q.currency_hi, it_q.currency_lo});
  assign sum_exc   = name_sum({it_q.exchange_hi, it_q.exchange_lo});
  assign date_term = 34'(it_q.date) * DATE_MUL;
  assign cur_term  = 22'(sum_cur) * CUR_MUL;
  assign exc_term  = 22'(sum_exc) * EXC_MUL;

  assign wk_valid_o      = v_q;
  assign wk_o.item       = it_q;
  assign wk_o.hash_raw   = HASH_W'(date_term + 34'(cur_term) + 34'(exc_term));
  assign wk_o.hash_price = HASH_W'(date_term + 34'(cur_term) + PRICE_TERM);
  assign wk_o.hash_cap   = HASH_W'(date_term + CAP_TERM + 34'(exc_term));

endmodule

`default_nettype wire

// ===== rtl/kmm_back.sv =====
// Back end: walks bucket chains in the head and entry memories, creates and
// updates entries and builds one result per item. Depends on kmm_pkg, kmm_ram.
`default_nettype none

module kmm_back #(
  parameter int BUCKETS = 4096,
  parameter int ENTRIES = 16384
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wk_valid_i,
  input  kmm_pkg::work_t wk_i,
  output logic           wk_pop_o,
  output logic           res_push_o,
  output kmm_pkg::out_t  res_o,
  input  logic           res_full_i,
  output logic           clearing_o
);
  import kmm_pkg::*;

  localparam int BKT_W = $clog2(BUCKETS);
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int PTR_W = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [26:0] date;
    logic [63:0] ch;
    logic [63:0] cl;
    logic [63:0] eh;
    logic [63:0] el;
  } key_t;

  typedef struct packed {
    key_t               key;
    logic signed [47:0] lo;
    logic signed [47:0] hi;
    logic [63:0]        cap;
    logic [PTR_W-1:0]   link;
  } entry_t;

  typedef enum logic [1:0] {
    TASK_RAW   = 2'd0,
    TASK_PRICE = 2'd1,
    TASK_CAP   = 2'd2
  } task_e;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HEAD  = 6'b000100,
    S_HPTR  = 6'b001000,
    S_ECMP  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  work_t            wk_q, wk_d;
  task_e            task_q, task_d;
  out_t             res_q, res_d;
  logic [PTR_W-1:0] used_q, used_d;
  logic [BKT_W-1:0] clr_q, clr_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;

  logic             hd_we, hd_re;
  logic [BKT_W-1:0] hd_waddr, hd_raddr;
  logic [PTR_W-1:0] hd_wdata, hd_rdata;
  logic             ent_we, ent_re;
  logic [IDX_W-1:0] ent_waddr, ent_raddr;
  entry_t           ent_wdata, ent_rdata;

  key_t             key;
  logic [BKT_W-1:0] bkt;
  logic             last_task, hit, miss, create_w;
  logic [PTR_W-1:0] head_cur;
  entry_t           upd;

  kmm_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_head_ram (
    .clk_i     (clk_i),
    .wr_en_i   (hd_we),
    .wr_addr_i (hd_waddr),
    .wr_data_i (hd_wdata),
    .rd_en_i   (hd_re),
    .rd_addr_i (hd_raddr),
    .rd_data_o (hd_rdata)
  );

  kmm_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ent_we),
    .wr_addr_i (ent_waddr),
    .wr_data_i (ent_wdata),
    .rd_en_i   (ent_re),
    .rd_addr_i (ent_raddr),
    .rd_data_o (ent_rdata)
  );

  // Key and bucket of the task in progress.
  always_comb begin
    key.date = wk_q.item.date;
    key.ch   = wk_q.item.currency_hi;
    key.cl   = wk_q.item.currency_lo;
    key.eh   = wk_q.item.exchange_hi;
    key.el   = wk_q.item.exchange_lo;
    bkt      = wk_q.hash_raw[BKT_W-1:0];
    case (task_q)
      TASK_PRICE: begin
        key.eh = NAME_PRICE_HI;
        key.el = 64'd0;
        bkt    = wk_q.hash_price[BKT_W-1:0];
      end
      TASK_CAP: begin
        key.ch = NAME_CAP_HI;
        key.cl = 64'd0;
        bkt    = wk_q.hash_cap[BKT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign last_task  = (wk_q.item.operation != OP_LOAD) || (task_q == TASK_CAP);
  assign head_cur   = (state_q == S_HPTR) ? hd_rdata : head_q;
  assign clearing_o = (state_q == S_CLEAR);
  assign res_o      = res_q;

  // Sequencer: chain walk, then hit or miss handling of each task.
  always_comb begin
    state_d   = state_q;
    wk_d      = wk_q;
    task_d    = task_q;
    res_d     = res_q;
    used_d    = used_q;
    clr_d     = clr_q;
    head_d    = head_q;
    ptr_d     = ptr_q;
    hd_we     = 1'b0;
    hd_re     = 1'b0;
    hd_waddr  = bkt;
    hd_raddr  = bkt;
    hd_wdata  = '0;
    ent_we    = 1'b0;
    ent_re    = 1'b0;
    ent_waddr = ptr_q;
    ent_raddr = ptr_q;
    ent_wdata = ent_rdata;
    wk_pop_o  = 1'b0;
    res_push_o = 1'b0;
    hit       = 1'b0;
    miss      = 1'b0;
    create_w  = 1'b0;
    upd       = ent_rdata;

    case (state_q)
      S_CLEAR: begin
        hd_we    = 1'b1;
        hd_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == BKT_W'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (wk_valid_i) begin
          wk_pop_o = 1'b1;
          wk_d     = wk_i;
          res_d    = '0;
          case (wk_i.item.operation)
            OP_PRICE: task_d = TASK_PRICE;
            OP_CAP:   task_d = TASK_CAP;
            default:  task_d = TASK_RAW;
          endcase
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        hd_re   = 1'b1;
        state_d = S_HPTR;
      end
      S_HPTR: begin
        head_d = hd_rdata;
        if (hd_rdata == '0) begin
          miss = 1'b1;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = IDX_W'(hd_rdata - 1'b1);
          ptr_d     = ent_raddr;
          state_d   = S_ECMP;
        end
      end
      S_ECMP: begin
        if (ent_rdata.key == key) begin
          hit = 1'b1;
        end else if (ent_rdata.link == '0) begin
          miss = 1'b1;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = IDX_W'(ent_rdata.link - 1'b1);
          ptr_d     = ent_raddr;
        end
      end
      S_DONE: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A missing key is created on a load while room is left.
    if (miss) begin
      if (wk_q.item.operation == OP_LOAD) begin
        if (used_q != PTR_W'(ENTRIES)) begin
          create_w       = 1'b1;
          ent_we         = 1'b1;
          ent_waddr      = used_q[IDX_W-1:0];
          ent_wdata.key  = key;
          ent_wdata.lo   = wk_q.item.low_price;
          ent_wdata.hi   = wk_q.item.high_price;
          ent_wdata.cap  = wk_q.item.capital;
          ent_wdata.link = head_cur;
          hd_we          = 1'b1;
          hd_waddr       = bkt;
          hd_wdata       = used_q + 1'b1;
          used_d         = used_q + 1'b1;
        end else begin
          res_d.status = ST_FULL;
        end
      end else begin
        res_d.status = ST_MISS;
      end
    end

    // A found key is aggregated on the price and cap tasks of a load, or reported on a query.
    if (hit) begin
      case (wk_q.item.operation)
        OP_LOAD: begin
          if (task_q == TASK_PRICE) begin
            if (wk_q.item.high_price > ent_rdata.hi) upd.hi = wk_q.item.high_price;
            if (wk_q.item.low_price < ent_rdata.lo) upd.lo = wk_q.item.low_price;
            ent_we    = 1'b1;
            ent_wdata = upd;
          end else if (task_q == TASK_CAP) begin
            upd.cap   = ent_rdata.cap + wk_q.item.capital;
            ent_we    = 1'b1;
            ent_wdata = upd;
          end
        end
        OP_EXACT: begin
          res_d.found_low     = ent_rdata.lo;
          res_d.found_high    = ent_rdata.hi;
          res_d.found_capital = ent_rdata.cap;
        end
        OP_PRICE: begin
          res_d.chosen_price = wk_q.item.want_max ? ent_rdata.hi : ent_rdata.lo;
        end
        default: begin
          res_d.found_capital = ent_rdata.cap;
        end
      endcase
    end

    // Move on to the next task or to the result.
    if (hit || miss) begin
      if (last_task) begin
        state_d = S_DONE;
      end else begin
        task_d  = (task_q == TASK_RAW) ? TASK_PRICE : TASK_CAP;
        state_d = S_HEAD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      used_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wk_q   <= wk_d;
    task_q <= task_d;
    res_q  <= res_d;
    head_q <= head_d;
    ptr_q  <= ptr_d;
  end

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= PTR_W'(ENTRIES))
    else $error("entry count beyond table size");

  a_create_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    create_w |=> used_q == $past(used_q) + 1'b1)
    else $error("entry creation did not advance the entry count");

  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == S_CLEAR) |-> $past(clr_q) == BKT_W'(BUCKETS - 1))
    else $error("bucket clear left before the last bucket");

  a_head_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hd_we && state_q != S_CLEAR) |-> hd_wdata != '0)
    else $error("empty pointer linked into a bucket");
`endif

endmodule

`default_nettype wire

// ===== rtl/keyed_min_max_sum_hash_map_unit.sv =====
// Keyed min/max/sum hash map. A query reads the bucket head and then compares the chain
// entries one by one; a load makes three such walks (raw, price and cap keys). Items pass
// the front end and a queue, and the back end works on one item at a time, taking a new
// item only after the result of the last one is queued.
// After reset the bucket heads are cleared, one per cycle, while full
// stays high; entry memories are not cleared.
`default_nettype none

module keyed_min_max_sum_hash_map_unit #(
  parameter int BUCKETS = 4096,
  parameter int ENTRIES = 16384
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  kmm_pkg::in_t  item_i,
  output logic          empty,
  input  logic          pop,
  output kmm_pkg::out_t result_o
);
  import kmm_pkg::*;

  logic  wk_valid, wk_ready, wk_full, wk_empty, wk_pop, clearing;
  work_t wk_front, wk_head;
  logic  res_push, res_full;
  out_t  res_back;

  // Front end: canonical names and bucket hashes.
  kmm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .hold_i     (clearing),
    .wk_valid_o (wk_valid),
    .wk_ready_i (wk_ready),
    .wk_o       (wk_front)
  );

  assign wk_ready = !wk_full;

  // Queue between front and back ends.
  kmm_fifo #(.T(work_t), .DEPTH(2)) u_wk_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wk_valid),
    .data_i  (wk_front),
    .full_o  (wk_full),
    .pop_i   (wk_pop),
    .data_o  (wk_head),
    .empty_o (wk_empty)
  );

  // Back end: chain walks and table updates.
  kmm_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wk_valid_i (!wk_empty),
    .wk_i       (wk_head),
    .wk_pop_o   (wk_pop),
    .res_push_o (res_push),
    .res_o      (res_back),
    .res_full_i (res_full),
    .clearing_o (clearing)
  );

  // Result queue.
  kmm_fifo #(.T(out_t), .DEPTH(2)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_back),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire
